// File: rtl/fas_pkg.sv
// ----------------------------------------------------------------------------
// fas_pkg - shared definitions for the fader ADC smoothing block
// Widths, reset values, register indexes and the divider status type.
// ----------------------------------------------------------------------------
package fas_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int COUNT_W    = 8;
    localparam int SUM_W      = 20;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 12;

    localparam logic [COUNT_W-1:0]  MIN_LEN         = 8'd3;
    localparam logic [COUNT_W-1:0]  RST_SAMPLE_CNT  = 8'd150;
    localparam logic [SAMPLE_W-1:0] RST_HYSTERESIS  = 12'd25;
    localparam logic [SAMPLE_W-1:0] RST_USABLE_MIN  = 12'd40;
    localparam logic [SAMPLE_W-1:0] RST_USABLE_MAX  = 12'd4020;
    localparam logic [SUM_W-1:0]    BYTE_MAX        = 20'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USABLE_MIN   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_USABLE_MAX   = 4'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// File: rtl/fas_div.sv
// ----------------------------------------------------------------------------
// fas_div - shared restoring divider
// One quotient bit per cycle; done pulses with the quotient in place.
// ----------------------------------------------------------------------------
module fas_div #(
    parameter int DIVIDEND_W = 20,
    parameter int DIVISOR_W  = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic [DIVIDEND_W-1:0] o_quotient,
    output fas_pkg::t_div_stat    o_stat
);
    import fas_pkg::*;

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DIVIDEND_W - 1);

    logic                  r_busy, r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem, r_div;
    logic [DIVISOR_W:0]    rem_sh, trial;

    assign rem_sh = {r_rem, r_quo[DIVIDEND_W-1]};
    assign trial  = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (!trial[DIVISOR_W]) begin
                r_rem <= trial[DIVISOR_W-1:0];
                r_quo <= {r_quo[DIVIDEND_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DIVISOR_W-1:0];
                r_quo <= {r_quo[DIVIDEND_W-2:0], 1'b0};
            end
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider started while busy");
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while still busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without a run");
`endif

endmodule

// File: rtl/fader_adc_smoothing.sv
// ----------------------------------------------------------------------------
// fader_adc_smoothing - block-averaged fader filter with median, EMA, hold
// Averages blocks of ADC samples, mixes in a median of three, smooths with
// an alpha 1/8 EMA, holds against small moves and scales the result to a byte.
// ----------------------------------------------------------------------------
//
//  channel | handshake                  | payload
//  --------+----------------------------+-------------------------------------
//  in      | i_in_valid, o_in_stall     | i_sample
//  out     | o_out_valid, i_out_stall   | mean, median, smoothed, held, byte
//  cfg     | i_cfg_valid, o_cfg_ready   | i_cfg_index, i_cfg_data
//
// A beat that does not end a block is taken without a stall. A block-ending
// beat stalls the input while the shared divider runs for the mean, then for
// the byte scaling, each a 20-bit quotient, with the EMA, hold and scale steps
// between and the output step last; with no byte division only the mean runs.
// A result waits in the output register while new beats are taken, and only
// a second finished result holds the sequencer. Reset is synchronous.
//
module fader_adc_smoothing (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [fas_pkg::SAMPLE_W-1:0]     i_sample,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [fas_pkg::SAMPLE_W-1:0]     o_block_average,
    output logic [fas_pkg::SAMPLE_W-1:0]     o_median_of_three,
    output logic [fas_pkg::SAMPLE_W-1:0]     o_smoothed,
    output logic [fas_pkg::SAMPLE_W-1:0]     o_held_value,
    output logic [fas_pkg::BYTE_W-1:0]       o_scaled_byte,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fas_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fas_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import fas_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DIV_AVG = 3'd1;
    localparam logic [2:0] S_EMA     = 3'd2;
    localparam logic [2:0] S_HOLD    = 3'd3;
    localparam logic [2:0] S_SCALE   = 3'd4;
    localparam logic [2:0] S_DIV_SC  = 3'd5;
    localparam logic [2:0] S_OUT     = 3'd6;

    // Configuration registers.
    logic [COUNT_W-1:0]  r_sample_count;
    logic [SAMPLE_W-1:0] r_hysteresis, r_usable_min, r_usable_max;

    // Filter state.
    logic [2:0]          r_state, n_state;
    logic [SUM_W-1:0]    r_sum;
    logic [COUNT_W-1:0]  r_idx;
    logic [SAMPLE_W-1:0] r_hist0, r_hist1, r_hist2;
    logic [SAMPLE_W-1:0] r_ema, r_held, r_avg, r_med;
    logic [BYTE_W-1:0]   r_scaled;
    logic                r_ema_seeded, r_held_seeded;

    // Output register.
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_o_avg, r_o_med, r_o_ema, r_o_held;
    logic [BYTE_W-1:0]   r_o_byte;

    // Shared divider.
    logic                div_start;
    logic [SUM_W-1:0]    div_dividend, div_quotient;
    logic [SAMPLE_W-1:0] div_divisor;
    t_div_stat           div_stat;

    logic                in_take, block_end, out_load;
    logic [COUNT_W-1:0]  len, idx_next;
    logic [SUM_W-1:0]    sum_next;
    logic [SAMPLE_W-1:0] med_lo, med_hi, med_val;
    logic [SAMPLE_W:0]   mix_sum;
    logic [SAMPLE_W+2:0] ema_acc;
    logic [SAMPLE_W-1:0] mix, ema_next, diff, span, offset;
    logic                range_empty, below_min;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_take     = i_in_valid && !o_in_stall;

    // Effective block length: short settings act as the minimum of three.
    assign len       = (r_sample_count < MIN_LEN) ? MIN_LEN : r_sample_count;
    assign sum_next  = r_sum + SUM_W'(i_sample);
    assign idx_next  = r_idx + 1'b1;
    assign block_end = (idx_next >= len);

    // Median of three as max(min(a,b), min(max(a,b),c)).
    assign med_lo  = (r_hist0 < r_hist1) ? r_hist0 : r_hist1;
    assign med_hi  = (r_hist0 < r_hist1) ? r_hist1 : r_hist0;
    assign med_val = (med_lo > ((med_hi < r_hist2) ? med_hi : r_hist2)) ? med_lo :
                     ((med_hi < r_hist2) ? med_hi : r_hist2);

    // The first mix seeds the EMA, so an unseeded update simply yields the mix.
    assign mix_sum  = {1'b0, r_med} + {1'b0, r_avg};
    assign mix      = mix_sum[SAMPLE_W:1];
    assign ema_acc  = {r_ema, 3'b000} - {3'b000, r_ema} + {3'b000, mix};
    assign ema_next = r_ema_seeded ? ema_acc[SAMPLE_W+2:3] : mix;

    assign diff = (r_ema > r_held) ? (r_ema - r_held) : (r_held - r_ema);

    assign range_empty = (r_usable_max <= r_usable_min);
    assign below_min   = (r_held <= r_usable_min);
    assign span        = r_usable_max - r_usable_min;
    assign offset      = r_held - r_usable_min;

    // The divider is loaded on the accepting beat for the mean and from the
    // scale step for the byte mapping, where offset*255 = offset*256 - offset.
    assign div_start    = (in_take && block_end) ||
                          (r_state == S_SCALE && !range_empty && !below_min);
    assign div_dividend = (r_state == S_SCALE) ?
                          ({offset, 8'h00} - SUM_W'(offset)) : sum_next;
    assign div_divisor  = (r_state == S_SCALE) ? span : SAMPLE_W'(len);

    fas_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (SAMPLE_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_quotient),
        .o_stat     (div_stat)
    );

    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (in_take && block_end) n_state = S_DIV_AVG;
            S_DIV_AVG: if (div_stat.done) n_state = S_EMA;
            S_EMA:     n_state = S_HOLD;
            S_HOLD:    n_state = S_SCALE;
            S_SCALE:   n_state = (range_empty || below_min) ? S_OUT : S_DIV_SC;
            S_DIV_SC:  if (div_stat.done) n_state = S_OUT;
            S_OUT:     if (out_load) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Control state, configuration and filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_sample_count <= RST_SAMPLE_CNT;
            r_hysteresis   <= RST_HYSTERESIS;
            r_usable_min   <= RST_USABLE_MIN;
            r_usable_max   <= RST_USABLE_MAX;
            r_sum          <= '0;
            r_idx          <= '0;
            r_hist0        <= '0;
            r_hist1        <= '0;
            r_hist2        <= '0;
            r_ema          <= '0;
            r_ema_seeded   <= 1'b0;
            r_held         <= '0;
            r_held_seeded  <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[COUNT_W-1:0];
                    CFG_HYSTERESIS:   r_hysteresis   <= i_cfg_data;
                    CFG_USABLE_MIN:   r_usable_min   <= i_cfg_data;
                    CFG_USABLE_MAX:   r_usable_max   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_take) begin
                r_hist0 <= r_hist1;
                r_hist1 <= r_hist2;
                r_hist2 <= i_sample;
                r_sum   <= block_end ? '0 : sum_next;
                r_idx   <= block_end ? '0 : idx_next;
            end
            if (r_state == S_EMA) begin
                r_ema        <= ema_next;
                r_ema_seeded <= 1'b1;
            end
            if (r_state == S_HOLD && (!r_held_seeded || diff > r_hysteresis)) begin
                r_held        <= r_ema;
                r_held_seeded <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV_AVG) begin
            r_med <= med_val;
            if (div_stat.done) begin
                r_avg <= div_quotient[SAMPLE_W-1:0];
            end
        end
        if (r_state == S_SCALE) begin
            r_scaled <= (range_empty || below_min) ? '0 : r_scaled;
        end
        if (r_state == S_DIV_SC && div_stat.done) begin
            r_scaled <= (div_quotient > BYTE_MAX) ? BYTE_MAX[BYTE_W-1:0] :
                        div_quotient[BYTE_W-1:0];
        end
        if (out_load) begin
            r_o_avg  <= r_avg;
            r_o_med  <= r_med;
            r_o_ema  <= r_ema;
            r_o_held <= r_held;
            r_o_byte <= r_scaled;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_block_average   = r_o_avg;
    assign o_median_of_three = r_o_med;
    assign o_smoothed        = r_o_ema;
    assign o_held_value      = r_o_held;
    assign o_scaled_byte     = r_o_byte;

`ifndef SYNTH
    a_idle_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_stat.busy)
        else $error("divider busy while sequencer idle");
    a_done_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV_AVG || r_state == S_DIV_SC))
        else $error("divider result outside a divide step");
    a_seed_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_seeded |-> r_ema_seeded)
        else $error("held value seeded before the EMA");
    a_scale_checked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_SC) |-> (!range_empty && !below_min))
        else $error("scaling divide with an empty or undershot range");
`endif

endmodule
